### rtl/windowed_majority_input_debounce_assert.svh
// assertion macros for the debounce block
// no dependencies; the asserting modules supply i_clk and i_rst_n
`ifndef WINDOWED_MAJORITY_INPUT_DEBOUNCE_ASSERT_SVH
`define WINDOWED_MAJORITY_INPUT_DEBOUNCE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define WMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define WMD_ASSERT_NOW(label, ante, cons)
`define WMD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/wmd_pkg.sv
// types and constants of the windowed majority debounce block
// no dependencies
`default_nettype none

package wmd_pkg;

    localparam int unsigned CNT_W = 16;

    typedef struct packed {
        logic channel;
        logic level;
    } t_in;

    typedef struct packed {
        logic             channel_out;
        logic             filtered_out;
        logic             decided;
        logic             rose;
        logic             fell;
        logic [CNT_W-1:0] edges_out;
    } t_out;

    // per-channel state word kept in the ram
    typedef struct packed {
        logic [CNT_W-1:0] edges;
        logic             filt;
        logic [CNT_W-1:0] highs;
        logic [CNT_W-1:0] samples;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd10;

endpackage

`default_nettype wire

### rtl/wmd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read during write of the same address returns old data
`default_nettype none

module wmd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/windowed_majority_input_debounce.sv
// top level of the windowed majority debounce filter
// depends on wmd_pkg, wmd_ram and windowed_majority_input_debounce_assert.svh
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out (t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (16 bit)
//
// one transaction per cycle sustained while the output is taken; a sample's steps, in order:
// state ram read at the accepting edge, then update, write back and output register once the output is free
// back-to-back samples of one channel use the forwarded last write instead of the ram data
// after reset all channel state reads as zero through per-channel valid bits, no clearing pass
// input stalls only while the update stage holds a sample and the output register is not taken
// samples of a channel at or above CHANNELS are taken and dropped without a result
`default_nettype none

module windowed_majority_input_debounce #(
    parameter int unsigned CHANNELS = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire wmd_pkg::t_in        i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output wmd_pkg::t_out            o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [15:0]         i_cfg_data
);

    import wmd_pkg::*;

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CNT_W-1:0] r_window;

    logic             r_s1_valid;
    logic [AW-1:0]    r_s1_idx;
    logic             r_s1_channel;
    logic             r_s1_level;

    logic             r_fwd_valid;
    logic [AW-1:0]    r_fwd_idx;
    t_entry           r_fwd_data;

    logic [CHANNELS-1:0] r_vld;

    logic             in_fire;
    logic             in_range;
    logic [AW-1:0]    in_idx;
    logic             s1_fire;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry           cur;
    t_entry           n_entry;
    t_out             n_out;
    logic             now_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_data;
        end
    end

    // stage 0: accept and issue the state read
    assign s1_fire    = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_idx     = AW'(i_in.channel);
    assign in_range   = !i_in.channel || (CHANNELS > 1);

    wmd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_idx),
        .i_wdata (n_entry),
        .i_re    (in_fire),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // stage 1: pick the current state, update, write back
    always_comb begin
        if (r_fwd_valid && r_fwd_idx == r_s1_idx) begin
            cur = r_fwd_data;
        end else if (r_vld[r_s1_idx]) begin
            cur = t_entry'(ram_rdata);
        end else begin
            cur = '0;
        end

        now_level = (cur.highs >= (r_window >> 1));
        n_entry   = cur;
        n_out     = '0;
        n_out.channel_out = r_s1_channel;

        if (cur.samples < r_window) begin
            n_entry.samples = cur.samples + CNT_W'(1);
            n_entry.highs   = cur.highs + CNT_W'(r_s1_level);
        end else begin
            n_entry.samples = '0;
            n_entry.highs   = '0;
            n_entry.filt    = now_level;
            n_out.decided   = 1'b1;
            n_out.rose      = !cur.filt && now_level;
            n_out.fell      = cur.filt && !now_level;
            if (!cur.filt && now_level) begin
                n_entry.edges = cur.edges + CNT_W'(1);
            end
        end

        n_out.filtered_out = n_entry.filt;
        n_out.edges_out    = n_entry.edges;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= in_fire && in_range;
            end
            if (s1_fire) begin
                r_fwd_valid       <= 1'b1;
                r_vld[r_s1_idx]   <= 1'b1;
                o_out_valid       <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_idx     <= in_idx;
            r_s1_channel <= i_in.channel;
            r_s1_level   <= i_in.level;
        end
        if (s1_fire) begin
            r_fwd_idx  <= r_s1_idx;
            r_fwd_data <= n_entry;
            o_out      <= n_out;
        end
    end

    `include "windowed_majority_input_debounce_assert.svh"

    `WMD_ASSERT_NOW(a_rose_decided, o_out_valid && o_out.rose, o_out.decided && o_out.filtered_out)
    `WMD_ASSERT_NOW(a_fell_decided, o_out_valid && o_out.fell, o_out.decided && !o_out.filtered_out)
    `WMD_ASSERT_NOW(a_stall_blocks, r_s1_valid && o_out_valid && !i_out_ready, !o_in_ready)
    `WMD_ASSERT_NEXT(a_update_shown, s1_fire, o_out_valid && r_fwd_valid)

endmodule

`default_nettype wire

### bench/windowed_majority_input_debounce_tb.sv
// self-checking bench for windowed_majority_input_debounce
// depends on wmd_pkg and the rtl of the block; predicts every result of every accepted sample
`default_nettype none

module windowed_majority_input_debounce_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wmd_pkg::*;

    localparam int CHANNELS    = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in        = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out        o_out;
    logic        o_cfg_ready;

    windowed_majority_input_debounce #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    // predicted filter state
    logic [15:0] window_len;
    logic [15:0] sample_cnt [CHANNELS];
    logic [15:0] high_cnt   [CHANNELS];
    logic        level_q    [CHANNELS];
    logic [15:0] rise_cnt   [CHANNELS];

    t_in  samples_to_send [$];
    t_out predicted_results [$];
    int   err_count   = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic in_taken    = 1'b0;
    logic hold_req    = 1'b0;
    logic rx_hold     = 1'b0;

    function automatic bit predict_filter(input t_in s, output t_out r);
        int   ch;
        logic now;
        ch = int'(s.channel);
        r  = '0;
        if (ch >= CHANNELS) return 1'b0;
        if (sample_cnt[ch] < window_len) begin
            sample_cnt[ch] = sample_cnt[ch] + 16'd1;
            if (s.level) high_cnt[ch] = high_cnt[ch] + 16'd1;
        end else begin
            // closing sample, not counted itself
            now        = (high_cnt[ch] >= (window_len >> 1));
            r.decided  = 1'b1;
            r.rose     = !level_q[ch] && now;
            r.fell     = level_q[ch] && !now;
            if (r.rose) rise_cnt[ch] = rise_cnt[ch] + 16'd1;
            sample_cnt[ch] = '0;
            high_cnt[ch]   = '0;
            level_q[ch]    = now;
        end
        r.channel_out  = s.channel;
        r.filtered_out = level_q[ch];
        r.edges_out    = rise_cnt[ch];
        return 1'b1;
    endfunction

    // driver: new transaction only once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in       <= samples_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_taken   <= 1'b0;
            window_len = WINDOW_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                sample_cnt[c] = '0;
                high_cnt[c]   = '0;
                level_q[c]    = 1'b0;
                rise_cnt[c]   = '0;
            end
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_cfg_valid && o_cfg_ready) window_len = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                if (predict_filter(i_in, want)) predicted_results.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result transaction: %p", o_out);
                    err_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (o_out.channel_out !== want.channel_out) begin
                        $error("channel_out: expected %0d, got %0d",
                               want.channel_out, o_out.channel_out);
                        err_count++;
                    end
                    if (o_out.filtered_out !== want.filtered_out) begin
                        $error("filtered_out: expected %0d, got %0d",
                               want.filtered_out, o_out.filtered_out);
                        err_count++;
                    end
                    if (o_out.decided !== want.decided) begin
                        $error("decided: expected %0d, got %0d", want.decided, o_out.decided);
                        err_count++;
                    end
                    if (o_out.rose !== want.rose) begin
                        $error("rose: expected %0d, got %0d", want.rose, o_out.rose);
                        err_count++;
                    end
                    if (o_out.fell !== want.fell) begin
                        $error("fell: expected %0d, got %0d", want.fell, o_out.fell);
                        err_count++;
                    end
                    if (o_out.edges_out !== want.edges_out) begin
                        $error("edges_out: expected %0d, got %0d",
                               want.edges_out, o_out.edges_out);
                        err_count++;
                    end
                end
            end
        end
    end

    // long receiver stall, the sender keeps offering meanwhile
    initial begin
        wait (hold_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    function automatic void push_sample(input logic ch, input logic lvl);
        t_in s;
        s.channel = ch;
        s.level   = lvl;
        samples_to_send.push_back(s);
    endfunction

    // returns at a rising edge once nothing is in flight
    task automatic drain();
        do @(posedge i_clk);
        while (samples_to_send.size() != 0 || i_in_valid || predicted_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [15:0] len);
        drain();
        @(negedge i_clk);
        i_cfg_data  <= len;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_window();
        case ($urandom_range(9))
            0, 1, 2:       return 16'($urandom_range(2));
            3, 4, 5, 6, 7: return 16'($urandom_range(16, 3));
            8:             return 16'($urandom_range(60, 17));
            default:       return WINDOW_RESET;
        endcase
    endfunction

    // bouncing lines: each channel holds a level for a while with some glitches, or random levels with noise_only
    task automatic queue_bursts(input int n, input bit noise_only);
        logic bias [CHANNELS];
        int   run_left [CHANNELS];
        int   ch;
        for (int c = 0; c < CHANNELS; c++) begin
            bias[c]     = 1'($urandom_range(1));
            run_left[c] = $urandom_range(40, 3);
        end
        for (int k = 0; k < n; k++) begin
            ch = $urandom_range(CHANNELS - 1);
            if (run_left[ch] == 0) begin
                bias[ch]     = !bias[ch];
                run_left[ch] = $urandom_range(40, 3);
            end
            run_left[ch]--;
            if (noise_only)
                push_sample(ch[0], 1'($urandom_range(1)));
            else
                push_sample(ch[0], ($urandom_range(99) < 12) ? !bias[ch] : bias[ch]);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit squeeze);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            write_window(pick_window());
            if (squeeze && chunk == 0) hold_req = 1'b1;
            queue_bursts(120, chunk == 3);
            drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 28;
        rx_idle_pct = 80;

        // reset window of ten: exactly half high on channel 0 is enough to rise
        for (int k = 0; k < 5; k++) push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        for (int k = 0; k < 5; k++) push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b0);
        drain();

        // zero window: every sample decides and the level goes high
        write_window(16'd0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        drain();

        // longest window, then shortened below the count already reached
        write_window(16'hFFFF);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b1);
        drain();
        write_window(16'd2);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b0);
        drain();

        run_phase(28, 80, 1'b0);
        run_phase(80, 28, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
